@@ sv/wgm_pkg.sv @@
`default_nettype none

package wgm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ANY  = 8'h3F;

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic matched;
        logic error;
    } result_t;

    // Broadcast to every cell
    typedef struct packed {
        logic       clear;
        logic       pat_we;
        logic       text_en;
        logic [7:0] ch;
        logic       pat_col;
    } cell_ctl_t;

    // Handed from one cell to the next
    typedef struct packed {
        logic col;
        logic step_new;
    } link_t;

endpackage

`default_nettype wire

@@ sv/wildcard_glob_matcher.sv @@
// A result is registered as its end-of-text request is accepted.
// Throughput: one request per cycle in every mode unless a pending result stalls; each
// text byte updates the cell row's whole match column; runs of '*' fold into one cell.
// Reset: rst_n clears the column, lengths and flags at once; a start-job request
// gives the same state. Pattern bytes are payload and need no reset.
`default_nettype none

module wildcard_glob_matcher (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               item_valid,
    output logic              item_ready,
    input  wgm_pkg::item_t    item,
    output logic              result_valid,
    input  wire               result_ready,
    output wgm_pkg::result_t  result
);

    logic                accept;
    logic                is_star_in;
    logic                pat_ok;
    logic                store;

    wgm_pkg::len_t       pat_len_reg;
    wgm_pkg::len_t       pat_len_next;
    wgm_pkg::len_t       slot_cnt_reg;
    wgm_pkg::len_t       slot_cnt_next;
    logic                text_started_reg;
    logic                text_started_next;
    logic                error_reg;
    logic                error_next;
    logic                last_star_reg;
    logic                last_star_next;
    logic                all_star_reg;
    logic                all_star_next;

    logic                result_valid_reg;
    wgm_pkg::result_t    result_reg;
    logic                matched_now;

    wgm_pkg::cell_ctl_t  ctl;
    wgm_pkg::link_t      links [wgm_pkg::MAX_PATTERN+1];
    logic [wgm_pkg::MAX_PATTERN-1:0] sel;
    logic [wgm_pkg::MAX_PATTERN-1:0] last_hit;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign is_star_in = (item.ch == wgm_pkg::CH_STAR);
    assign pat_ok     = !text_started_reg
                        && (pat_len_reg != wgm_pkg::len_t'(wgm_pkg::MAX_PATTERN));
    // Drop a star that directly follows a star: it leaves the column unchanged
    assign store      = !(is_star_in && last_star_reg);

    always_comb
    begin
        pat_len_next      = pat_len_reg;
        slot_cnt_next     = slot_cnt_reg;
        text_started_next = text_started_reg;
        error_next        = error_reg;
        last_star_next    = last_star_reg;
        all_star_next     = all_star_reg;
        ctl               = '0;
        ctl.ch            = item.ch;
        ctl.pat_col       = all_star_reg && is_star_in;
        if (accept)
        begin
            unique case (item.mode)
                wgm_pkg::MODE_START:
                begin
                    pat_len_next      = '0;
                    slot_cnt_next     = '0;
                    text_started_next = 1'b0;
                    error_next        = 1'b0;
                    last_star_next    = 1'b0;
                    all_star_next     = 1'b1;
                    ctl.clear         = 1'b1;
                end
                wgm_pkg::MODE_PATTERN:
                begin
                    if (pat_ok)
                    begin
                        pat_len_next   = pat_len_reg + 1'b1;
                        last_star_next = is_star_in;
                        all_star_next  = all_star_reg && is_star_in;
                        if (store)
                        begin
                            slot_cnt_next = slot_cnt_reg + 1'b1;
                            ctl.pat_we    = 1'b1;
                        end
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
                wgm_pkg::MODE_TEXT:
                begin
                    text_started_next = 1'b1;
                    ctl.text_en       = 1'b1;
                end
                wgm_pkg::MODE_END:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg      <= '0;
            slot_cnt_reg     <= '0;
            text_started_reg <= 1'b0;
            error_reg        <= 1'b0;
            last_star_reg    <= 1'b0;
            all_star_reg     <= 1'b1;
        end
        else
        begin
            pat_len_reg      <= pat_len_next;
            slot_cnt_reg     <= slot_cnt_next;
            text_started_reg <= text_started_next;
            error_reg        <= error_next;
            last_star_reg    <= last_star_next;
            all_star_reg     <= all_star_next;
        end
    end

    // Empty prefix matches only the empty text
    assign links[0].col      = !text_started_reg;
    assign links[0].step_new = 1'b0;

    for (genvar i = 0; i < wgm_pkg::MAX_PATTERN; i++)
    begin : g_cell
        assign sel[i]      = (slot_cnt_reg == wgm_pkg::len_t'(i));
        assign last_hit[i] = links[i+1].col && (slot_cnt_reg == wgm_pkg::len_t'(i + 1));

        wgm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .sel   (sel[i]),
            .prev  (links[i]),
            .link  (links[i+1])
        );
    end

    assign matched_now = (slot_cnt_reg == '0) ? !text_started_reg : (|last_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && (item.mode == wgm_pkg::MODE_END))
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.mode == wgm_pkg::MODE_END))
        begin
            result_reg.matched <= matched_now;
            result_reg.error   <= error_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_slots_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        slot_cnt_reg <= pat_len_reg)
        else $error("stored slots exceed pattern length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pat_len_reg <= wgm_pkg::len_t'(wgm_pkg::MAX_PATTERN))
        else $error("pattern length beyond bound");

    a_empty_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (pat_len_reg == '0) == (slot_cnt_reg == '0))
        else $error("slot count and pattern length disagree on empty");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg && !(accept && (item.mode == wgm_pkg::MODE_START))) |=> error_reg)
        else $error("error flag dropped without start job");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(accept && (item.mode == wgm_pkg::MODE_END)))
        else $error("result without end-of-text request");

endmodule

`default_nettype wire

@@ sv/wgm_cell.sv @@
`default_nettype none

module wgm_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wgm_pkg::cell_ctl_t    ctl,
    input  wire                   sel,
    input  wgm_pkg::link_t        prev,
    output wgm_pkg::link_t        link
);

    logic       col_reg;
    logic       col_next;
    logic [7:0] char_reg;
    logic       is_star;
    logic       char_hit;
    logic       step_new;

    assign is_star  = (char_reg == wgm_pkg::CH_STAR);
    assign char_hit = (char_reg == ctl.ch) || (char_reg == wgm_pkg::CH_ANY);
    // New column bit as if this slot held a plain byte or '?'
    assign step_new = prev.col & char_hit;

    always_comb
    begin
        col_next = col_reg;
        priority if (ctl.clear)
        begin
            col_next = 1'b0;
        end
        else if (ctl.pat_we && sel)
        begin
            col_next = ctl.pat_col;
        end
        else if (ctl.text_en)
        begin
            // A star never follows a star here, so the neighbour's plain result is its new bit
            col_next = is_star ? (prev.step_new | col_reg) : step_new;
        end
        else
        begin
            col_next = col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pat_we && sel)
        begin
            char_reg <= ctl.ch;
        end
    end

    assign link.col      = col_reg;
    assign link.step_new = step_new;

endmodule

`default_nettype wire

@@ verif/tb_wildcard_glob_matcher.sv @@
`timescale 1ns / 100ps

module tb_wildcard_glob_matcher;

    localparam int ITEM_TARGET    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [7:0] ALPHA_BASE = 8'h61;

    typedef struct packed {
        wgm_pkg::item_t   req;
        logic [6:0]       reps;
        logic             typed;
        wgm_pkg::result_t want;
    } script_row_t;

    // Opening script: verdicts typed in where they are obvious, the rest predicted
    localparam script_row_t SCRIPT [27] = '{
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b1, '{1'b1, 1'b0}},
        '{'{wgm_pkg::MODE_TEXT,    8'h61}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'hFF}, 7'd1,  1'b1, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_START,   8'hFF}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_PATTERN, wgm_pkg::CH_STAR}, 7'd1, 1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b1, '{1'b1, 1'b0}},
        '{'{wgm_pkg::MODE_TEXT,    8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_TEXT,    8'hFF}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b1, '{1'b1, 1'b0}},
        '{'{wgm_pkg::MODE_PATTERN, 8'h78}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b1, '{1'b1, 1'b1}},
        '{'{wgm_pkg::MODE_START,   8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_PATTERN, wgm_pkg::CH_ANY}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_PATTERN, 8'hFF}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_TEXT,    8'h80}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_TEXT,    8'hFF}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_TEXT,    8'h55}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_START,   8'h5A}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_PATTERN, wgm_pkg::CH_STAR}, 7'd64, 1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_PATTERN, 8'h7A}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b1, '{1'b1, 1'b1}},
        '{'{wgm_pkg::MODE_TEXT,    8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_START,   8'h00}, 7'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{wgm_pkg::MODE_END,     8'h00}, 7'd1,  1'b1, '{1'b1, 1'b0}}
    };

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    wgm_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    wgm_pkg::result_t result;

    // Matcher state as predicted; bit 0 of the column is the empty-prefix bit
    logic [7:0]                  glob_pat [wgm_pkg::MAX_PATTERN];
    int                          glob_len       = 0;
    bit [wgm_pkg::MAX_PATTERN:0] glob_col       = 1;
    bit                          glob_text_seen = 1'b0;
    bit                          glob_err       = 1'b0;

    wgm_pkg::result_t verdicts_due [$];
    int               typed_at [$];
    wgm_pkg::result_t typed_val [$];

    int sent_count     = 0;
    int accepted_items = 0;
    int verdicts_seen  = 0;
    int job_count      = 0;
    int bad_count      = 0;
    int idle_cycles    = 0;
    int tx_calm        = 0;
    int rx_calm        = 0;
    bit hold_req       = 1'b0;

    wildcard_glob_matcher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    task automatic note_failure(input string what, input wgm_pkg::result_t want,
                                input wgm_pkg::result_t got);
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s: want matched=%0b error=%0b, got matched=%0b error=%0b",
                     $realtime, what, want.matched, want.error, got.matched, got.error);
        end
    endtask

    task automatic glob_predict(input wgm_pkg::item_t r);
        wgm_pkg::result_t v;
        logic             prev_old;
        logic             prev_new;
        logic             here_old;
        logic             b;
        int               j;
        case (r.mode)
            wgm_pkg::MODE_START:
            begin
                glob_len       = 0;
                glob_col       = 1;
                glob_text_seen = 1'b0;
                glob_err       = 1'b0;
            end
            wgm_pkg::MODE_PATTERN:
            begin
                if (glob_text_seen || glob_len >= wgm_pkg::MAX_PATTERN)
                    glob_err = 1'b1;
                else
                begin
                    glob_pat[glob_len]   = r.ch;
                    glob_col[glob_len+1] = glob_col[glob_len] && (r.ch == wgm_pkg::CH_STAR);
                    glob_len++;
                end
            end
            wgm_pkg::MODE_TEXT:
            begin
                prev_old = glob_col[0];
                prev_new = 1'b0;
                for (j = 1; j <= glob_len; j++)
                begin
                    here_old = glob_col[j];
                    if (glob_pat[j-1] == wgm_pkg::CH_STAR)
                        b = prev_new | here_old;
                    else if (glob_pat[j-1] == wgm_pkg::CH_ANY)
                        b = prev_old;
                    else
                        b = prev_old && (glob_pat[j-1] == r.ch);
                    glob_col[j] = b;
                    prev_old    = here_old;
                    prev_new    = b;
                end
                glob_col[0]    = 1'b0;
                glob_text_seen = 1'b1;
            end
            default:
            begin
                v.matched = glob_col[glob_len];
                v.error   = glob_err;
                // A hand-written verdict from the opening script takes precedence
                if (typed_at.size() != 0 && typed_at[0] == accepted_items)
                begin
                    void'(typed_at.pop_front());
                    v = typed_val.pop_front();
                end
                verdicts_due.push_back(v);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        wgm_pkg::result_t want;
        bit               moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                glob_predict(item);
                accepted_items++;
                moved = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                verdicts_seen++;
                moved = 1'b1;
                if (verdicts_due.size() == 0)
                    note_failure("unexpected result", '0, result);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (result.matched !== want.matched || result.error !== want.error)
                        note_failure("result mismatch", want, result);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, calm stretches, one long hold-off on request
    initial
    begin
        int gap;
        forever
        begin
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = (rx_calm > 0) ? 0 : $urandom_range(0, 6);
                if (rx_calm > 0)
                    rx_calm--;
                else if ($urandom_range(0, 15) == 0)
                    rx_calm = $urandom_range(10, 40);
                if (gap > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!(rst_n && result_valid))
                @(posedge clk);
        end
    end

    function automatic wgm_pkg::item_t make_req(input wgm_pkg::mode_t m, input logic [7:0] c);
        wgm_pkg::item_t r;
        r.mode = m;
        r.ch   = c;
        return r;
    endfunction

    function automatic logic [7:0] pick_pat_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return wgm_pkg::CH_STAR;
        if (k < 5)
            return wgm_pkg::CH_ANY;
        if (k < 9)
            return ALPHA_BASE + 8'(k % 3);
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 7) != 0)
            return ALPHA_BASE + 8'($urandom_range(0, 2));
        return 8'($urandom);
    endfunction

    task automatic offer_request(input wgm_pkg::item_t r);
        int gap;
        gap = (tx_calm > 0) ? 0 : $urandom_range(0, 6);
        if (tx_calm > 0)
            tx_calm--;
        else if ($urandom_range(0, 15) == 0)
            tx_calm = $urandom_range(10, 40);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= r;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic run_job();
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        int         plen;
        job_count++;
        if ($urandom_range(0, 9) != 0)
            offer_request(make_req(wgm_pkg::MODE_START, 8'($urandom)));
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
        repeat (plen) pat.push_back(pick_pat_byte());
        foreach (pat[i])
            offer_request(make_req(wgm_pkg::MODE_PATTERN, pat[i]));
        if ($urandom_range(0, 1) != 0)
        begin
            // Build a text the accepted pattern should match, then maybe spoil it
            foreach (pat[i])
            begin
                if (i >= wgm_pkg::MAX_PATTERN)
                    break;
                if (pat[i] == wgm_pkg::CH_STAR)
                    repeat ($urandom_range(0, 3)) txt.push_back(pick_text_byte());
                else if (pat[i] == wgm_pkg::CH_ANY)
                    txt.push_back(8'($urandom));
                else
                    txt.push_back(pat[i]);
            end
            if (txt.size() != 0 && $urandom_range(0, 3) == 0)
                txt[$urandom_range(0, txt.size() - 1)] = pick_text_byte();
        end
        else
        begin
            repeat ($urandom_range(0, 8)) txt.push_back(pick_text_byte());
        end
        foreach (txt[i])
            offer_request(make_req(wgm_pkg::MODE_TEXT, txt[i]));
        offer_request(make_req(wgm_pkg::MODE_END, 8'($urandom)));
        case ($urandom_range(0, 7))
            0:
            begin
                offer_request(make_req(wgm_pkg::MODE_PATTERN, pick_pat_byte()));
                offer_request(make_req(wgm_pkg::MODE_END, 8'($urandom)));
            end
            1:
            begin
                repeat ($urandom_range(1, 3))
                    offer_request(make_req(wgm_pkg::MODE_TEXT, pick_text_byte()));
                offer_request(make_req(wgm_pkg::MODE_END, 8'($urandom)));
            end
            2:
            begin
                repeat ($urandom_range(1, 4))
                    offer_request(wgm_pkg::item_t'(10'($urandom)));
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].typed)
            begin
                typed_at.push_back(sent_count);
                typed_val.push_back(SCRIPT[i].want);
            end
            repeat (SCRIPT[i].reps) offer_request(SCRIPT[i].req);
        end

        // Stall the result side while verdicts keep coming, so the input backs up
        hold_req = 1'b1;
        offer_request(make_req(wgm_pkg::MODE_START, 8'h00));
        offer_request(make_req(wgm_pkg::MODE_PATTERN, wgm_pkg::CH_STAR));
        repeat (30) offer_request(make_req(wgm_pkg::MODE_END, 8'($urandom)));

        while (sent_count < ITEM_TARGET)
            run_job();
        item_valid <= 1'b0;

        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d requests in %0d random jobs plus the opening script; %0d verdicts",
                 sent_count, job_count, verdicts_seen);
        $display("Included pattern overflow, pattern after text and a %0d-cycle result stall",
                 HOLD_CYCLES);
        if (bad_count == 0 && verdicts_due.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d failures", bad_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
